/* rtl/stm_pkg.sv */
// Package for the subnet table match core: entry type, status, opcode and
// family codes, and the prefix mask builder.
// No dependencies.
`default_nettype none

package stm_pkg;

   // Request opcodes
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_MATCH = 1'b1;

   // Address families
   localparam logic FAM_V4 = 1'b0;
   localparam logic FAM_V6 = 1'b1;

   // Response status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NOMATCH = 2'd1;
   localparam logic [1:0] STATUS_RANGE   = 2'd2;
   localparam logic [1:0] STATUS_FULL    = 2'd3;

   // Longest legal prefix per family
   localparam logic [7:0] PREFIX_MAX_V4 = 8'd32;
   localparam logic [7:0] PREFIX_MAX_V6 = 8'd128;

   // IPv4 lives in the top 32 bits of the high half
   localparam logic [63:0] V4_PART = 64'hFFFF_FFFF_0000_0000;

   // One stored subnet
   typedef struct packed {
      logic        family;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [63:0] mask_hi;
      logic [63:0] mask_lo;
   } entry_type;

   // Top len bits set of a 128-bit mask; each bit is an independent compare
   function automatic logic [127:0] prefix_mask(input logic [7:0] len);
      logic [127:0] mask;
      mask = '0;
      for (int i = 0; i < 128; i++) begin
         mask[127 - i] = (8'(i) < len);
      end
      return mask;
   endfunction

endpackage

`default_nettype wire

/* rtl/subnet_table_match_core.sv */
// Subnet table match core: stores subnets and matches addresses by prefix.
// Add: request latched, then S_ADD writes a legal entry and registers the result.
// Match: one stored entry compared per cycle through a registered memory read;
// result in the next cycle on an empty table, else after a hit or the last entry.
// busy stays high until the result is produced; the receiver cannot stall.
// Synchronous active-high reset empties the table; entry contents are not cleared.
`default_nettype none

module subnet_table_match_core
   import stm_pkg::*;
#(
   parameter int MAX_SUBNETS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic        req_opcode,
   input  wire logic        req_family,
   input  wire logic [63:0] req_addr_hi,
   input  wire logic [63:0] req_addr_lo,
   input  wire logic        req_mask_given,
   input  wire logic [7:0]  req_prefix_len,
   input  wire logic [63:0] req_mask_hi,
   input  wire logic [63:0] req_mask_lo,
   output      logic        rsp_strobe,
   output      logic [1:0]  rsp_status
);

   localparam int CNT_W = $clog2(MAX_SUBNETS + 1);
   localparam int IDX_W = (MAX_SUBNETS > 1) ? $clog2(MAX_SUBNETS) : 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SUBNETS);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_ADD  = 3'b010,
      S_SCAN = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             rd_last_ff, rd_last_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;

   // Latched request payload
   logic        family_ff;
   logic [63:0] addr_hi_ff, addr_lo_ff;
   logic        mask_given_ff;
   logic [7:0]  prefix_len_ff;
   logic [63:0] mask_hi_ff, mask_lo_ff;

   entry_type entry_mem [MAX_SUBNETS];
   entry_type rd_ff;
   entry_type wr_entry;

   logic             accept;
   logic             issue;
   logic             wr_en;
   logic             hit;
   logic             table_full;
   logic             prefix_bad;
   logic [127:0]     built_mask;
   logic [63:0]      eff_mask_hi, eff_mask_lo;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // Build the entry for an add: explicit or prefix mask, IPv4 trimmed
   always_comb begin
      built_mask = prefix_mask(prefix_len_ff);
      if (mask_given_ff) begin
         eff_mask_hi = mask_hi_ff;
         eff_mask_lo = mask_lo_ff;
      end else begin
         eff_mask_hi = built_mask[127:64];
         eff_mask_lo = built_mask[63:0];
      end
      wr_entry.family = family_ff;
      if (family_ff == FAM_V6) begin
         wr_entry.addr_hi = addr_hi_ff;
         wr_entry.addr_lo = addr_lo_ff;
         wr_entry.mask_hi = eff_mask_hi;
         wr_entry.mask_lo = eff_mask_lo;
      end else begin
         wr_entry.addr_hi = addr_hi_ff & V4_PART;
         wr_entry.addr_lo = '0;
         wr_entry.mask_hi = eff_mask_hi & V4_PART;
         wr_entry.mask_lo = '0;
      end
   end

   assign table_full = (count_ff == CNT_MAX);
   assign prefix_bad = !mask_given_ff &&
                       (prefix_len_ff > ((family_ff == FAM_V6) ? PREFIX_MAX_V6
                                                               : PREFIX_MAX_V4));
   assign wr_en = (state_ff == S_ADD) && !table_full && !prefix_bad;

   // Shared compare unit: one registered entry against the request address
   assign hit = rd_vld_ff && (rd_ff.family == family_ff) &&
                (((addr_hi_ff ^ rd_ff.addr_hi) & rd_ff.mask_hi) == 64'd0) &&
                (((addr_lo_ff ^ rd_ff.addr_lo) & rd_ff.mask_lo) == 64'd0);

   assign issue = (state_ff == S_SCAN) && (ptr_ff < count_ff);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      rd_vld_in     = issue;
      rd_last_in    = issue && ((ptr_ff + CNT_ONE) == count_ff);
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         S_IDLE: begin
            rd_vld_in = 1'b0;
            ptr_in    = '0;
            if (accept) begin
               if (req_opcode == OP_ADD) begin
                  state_in = S_ADD;
               end else if (count_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STATUS_NOMATCH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_ADD: begin
            state_in      = S_IDLE;
            rsp_strobe_in = 1'b1;
            if (table_full) begin
               rsp_status_in = STATUS_FULL;
            end else if (prefix_bad) begin
               rsp_status_in = STATUS_RANGE;
            end else begin
               rsp_status_in = STATUS_OK;
               count_in      = count_ff + CNT_ONE;
            end
         end
         S_SCAN: begin
            if (issue) begin
               ptr_in = ptr_ff + CNT_ONE;
            end
            // finish on the first hit or after the last entry
            if (hit) begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_OK;
            end else if (rd_vld_ff && rd_last_ff) begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_NOMATCH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         ptr_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         rd_last_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ptr_ff        <= ptr_in;
         rd_vld_ff     <= rd_vld_in;
         rd_last_ff    <= rd_last_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers: hold the request for the whole operation
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      if (accept) begin
         family_ff     <= req_family;
         addr_hi_ff    <= req_addr_hi;
         addr_lo_ff    <= req_addr_lo;
         mask_given_ff <= req_mask_given;
         prefix_len_ff <= req_prefix_len;
         mask_hi_ff    <= req_mask_hi;
         mask_lo_ff    <= req_mask_lo;
      end
   end

   // Entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[count_ff[IDX_W-1:0]] <= wr_entry;
      end
      if (issue) begin
         rd_ff <= entry_mem[ptr_ff[IDX_W-1:0]];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Testbench for subnet_table_match_core: sends add and match commands, predicts
// each status from a local copy of the subnet table and checks every response.
// Depends on stm_pkg and the core RTL.
module tb_top;
   import stm_pkg::*;

   localparam int TABLE_DEPTH  = 16;
   localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;
   localparam int PHASE_CMDS   = 317;

   typedef struct packed {
      logic        opcode;
      logic        family;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic        mask_given;
      logic [7:0]  prefix_len;
      logic [63:0] mask_hi;
      logic [63:0] mask_lo;
   } subnet_cmd_type;

   logic        clock;
   logic        reset          = 1'b1;
   logic        start          = 1'b0;
   logic        req_opcode     = OP_ADD;
   logic        req_family     = FAM_V4;
   logic [63:0] req_addr_hi    = '0;
   logic [63:0] req_addr_lo    = '0;
   logic        req_mask_given = 1'b0;
   logic [7:0]  req_prefix_len = '0;
   logic [63:0] req_mask_hi    = '0;
   logic [63:0] req_mask_lo    = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;

   subnet_cmd_type cmd_q[$];     // commands waiting for their start transfer
   logic [1:0]  status_owed[$];  // statuses due, oldest first
   entry_type   planted_q[$];    // subnets the stimulus expects to land
   entry_type   tbl_entries[TABLE_DEPTH];
   int          tbl_count   = 0;
   int          idle_pct    = 38;
   int          fail_count  = 0;
   int          n_adds      = 0;
   int          n_matches   = 0;
   int          status_seen[4] = '{0, 0, 0, 0};

   subnet_table_match_core #(
      .MAX_SUBNETS(TABLE_DEPTH)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_family    (req_family),
      .req_addr_hi   (req_addr_hi),
      .req_addr_lo   (req_addr_lo),
      .req_mask_given(req_mask_given),
      .req_prefix_len(req_prefix_len),
      .req_mask_hi   (req_mask_hi),
      .req_mask_lo   (req_mask_lo),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Hard stop in case the core hangs
   initial begin
      #4_000_000;
      $display("Run timed out with %0d commands and %0d statuses outstanding",
               cmd_q.size(), status_owed.size());
      $display("subnet_table_match_core: mismatch");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      fail_count++;
      $display("ERROR @%0t: %s", $time, what);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Top len bits of a 128-bit mask
   function automatic logic [127:0] prefix_bits(input logic [7:0] len);
      if (len == 8'd0) return '0;
      return {128{1'b1}} << (128 - len);
   endfunction

   function automatic logic add_legal(input subnet_cmd_type c);
      return c.mask_given ||
             c.prefix_len <= ((c.family == FAM_V6) ? PREFIX_MAX_V6 : PREFIX_MAX_V4);
   endfunction

   // Subnet as stored: IPv4 keeps only the top 32 bits of the high half
   function automatic entry_type entry_of(input subnet_cmd_type c);
      entry_type    e;
      logic [127:0] m;
      m = c.mask_given ? {c.mask_hi, c.mask_lo} : prefix_bits(c.prefix_len);
      e.family  = c.family;
      e.addr_hi = c.addr_hi;
      e.addr_lo = c.addr_lo;
      e.mask_hi = m[127:64];
      e.mask_lo = m[63:0];
      if (c.family == FAM_V4) begin
         e.addr_hi = c.addr_hi & V4_PART;
         e.addr_lo = '0;
         e.mask_hi = m[127:64] & V4_PART;
         e.mask_lo = '0;
      end
      return e;
   endfunction

   // Advance the table copy by one command and return its status
   function automatic logic [1:0] apply_to_table(input subnet_cmd_type c);
      logic [1:0] st;
      st = STATUS_NOMATCH;
      if (c.opcode == OP_MATCH) begin
         for (int k = 0; k < tbl_count; k++) begin
            if (tbl_entries[k].family == c.family
                && ((c.addr_hi ^ tbl_entries[k].addr_hi) & tbl_entries[k].mask_hi) == '0
                && ((c.addr_lo ^ tbl_entries[k].addr_lo) & tbl_entries[k].mask_lo) == '0)
               st = STATUS_OK;
         end
      end else if (tbl_count == TABLE_DEPTH) begin
         st = STATUS_FULL;
      end else if (!add_legal(c)) begin
         st = STATUS_RANGE;
      end else begin
         tbl_entries[tbl_count] = entry_of(c);
         tbl_count++;
         st = STATUS_OK;
      end
      return st;
   endfunction

   function automatic subnet_cmd_type mk_cmd(input logic op, input logic fam,
                                          input logic [63:0] ahi, input logic [63:0] alo,
                                          input logic given, input logic [7:0] len,
                                          input logic [63:0] mhi, input logic [63:0] mlo);
      return '{op, fam, ahi, alo, given, len, mhi, mlo};
   endfunction

   task automatic queue_cmd(input subnet_cmd_type c);
      cmd_q.push_back(c);
      if (c.opcode == OP_ADD && planted_q.size() < TABLE_DEPTH && add_legal(c))
         planted_q.push_back(entry_of(c));
   endtask

   // Add with a legal prefix or explicit mask, or one with a prefix too long
   function automatic subnet_cmd_type rand_add(input logic legal);
      logic       fam;
      logic       given;
      logic [7:0] lim;
      logic [7:0] len;
      fam   = 1'($urandom_range(0, 1));
      lim   = (fam == FAM_V6) ? PREFIX_MAX_V6 : PREFIX_MAX_V4;
      given = legal && ($urandom_range(0, 99) < 25);
      if (!legal) begin
         len = 8'($urandom_range(int'(lim) + 1, 255));
      end else if (given) begin
         len = 8'($urandom_range(0, 255));
      end else begin
         case ($urandom_range(0, 4))
            0: len = 8'd1;
            1: len = lim;
            2: len = (fam == FAM_V6) ? 8'($urandom_range(63, 65))
                                     : 8'($urandom_range(31, 32));
            default: len = 8'($urandom_range(1, int'(lim)));
         endcase
      end
      return mk_cmd(OP_ADD, fam, rand64(), rand64(), given, len, rand64(), rand64());
   endfunction

   // Match near a planted subnet (hit or one masked bit off), or pure noise
   function automatic subnet_cmd_type rand_match();
      subnet_cmd_type c;
      entry_type    e;
      logic [127:0] m;
      logic [127:0] flip;
      int           pick;
      int           pos;
      c = mk_cmd(OP_MATCH, 1'($urandom_range(0, 1)), rand64(), rand64(),
                 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), rand64(), rand64());
      pick = $urandom_range(0, 99);
      if (planted_q.size() == 0 || pick < 25) return c;
      e    = planted_q[$urandom_range(0, planted_q.size() - 1)];
      m    = {e.mask_hi, e.mask_lo};
      flip = {c.addr_hi, c.addr_lo} & ~m;
      if (pick >= 70 && m != '0) begin
         pos = $urandom_range(0, 127);
         while (!m[pos]) pos = (pos + 1) % 128;
         flip[pos] = 1'b1;
      end
      {c.addr_hi, c.addr_lo} = {e.addr_hi, e.addr_lo} ^ flip;
      c.family = ($urandom_range(0, 9) == 0) ? ~e.family : e.family;
      return c;
   endfunction

   // Keep one slot free for the catch-all subnet at the end
   function automatic subnet_cmd_type rand_cmd();
      if (planted_q.size() < TABLE_DEPTH - 1) begin
         if ($urandom_range(0, 99) < 35) return rand_add($urandom_range(0, 99) >= 15);
      end else if ($urandom_range(0, 99) < 8) begin
         return rand_add(1'b0);
      end
      return rand_match();
   endfunction

   task automatic run_phase(input int pct, input int count);
      idle_pct = pct;
      repeat (count) queue_cmd(rand_cmd());
      while (cmd_q.size() != 0) @(posedge clock);
   endtask

   // Driver: present the head command, retire it on the start transfer
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (start) begin
            status_owed.push_back(apply_to_table(cmd_q[0]));
            if (cmd_q[0].opcode == OP_MATCH) n_matches++;
            else n_adds++;
            void'(cmd_q.pop_front());
         end
         if (cmd_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            start          <= 1'b1;
            req_opcode     <= cmd_q[0].opcode;
            req_family     <= cmd_q[0].family;
            req_addr_hi    <= cmd_q[0].addr_hi;
            req_addr_lo    <= cmd_q[0].addr_lo;
            req_mask_given <= cmd_q[0].mask_given;
            req_prefix_len <= cmd_q[0].prefix_len;
            req_mask_hi    <= cmd_q[0].mask_hi;
            req_mask_lo    <= cmd_q[0].mask_lo;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: compare each strobed status with the oldest one due
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         status_seen[rsp_status]++;
         if (status_owed.size() == 0) begin
            flag_mismatch($sformatf("response with nothing due, status %0d", rsp_status));
         end else begin
            if (rsp_status !== status_owed[0])
               flag_mismatch($sformatf("status %0d, predicted %0d", rsp_status,
                                       status_owed[0]));
            void'(status_owed.pop_front());
         end
      end
   end

   // Stimulus
   initial begin
      while (reset) @(posedge clock);

      // Empty table, prefix range errors, then boundary prefixes and explicit masks
      queue_cmd(mk_cmd(OP_MATCH, FAM_V4, 64'hC0A8_0101_DEAD_BEEF, '0, 1'b0, '0, '0, '0));
      queue_cmd(mk_cmd(OP_MATCH, FAM_V6, '1, '1, 1'b0, '0, '0, '0));
      queue_cmd(mk_cmd(OP_ADD, FAM_V4, 64'hC0A8_0101_0000_0000, '0, 1'b0, 8'd33, '0, '0));
      queue_cmd(mk_cmd(OP_ADD, FAM_V4, 64'hC0A8_0101_0000_0000, '0, 1'b0, 8'd255, '0, '0));
      queue_cmd(mk_cmd(OP_ADD, FAM_V6, '1, '1, 1'b0, 8'd129, '0, '0));
      queue_cmd(mk_cmd(OP_ADD, FAM_V6, '1, '1, 1'b0, 8'd255, '0, '0));
      queue_cmd(mk_cmd(OP_ADD, FAM_V4, 64'hC0A8_0101_1234_5678, rand64(), 1'b0, 8'd32,
                       rand64(), rand64()));
      queue_cmd(mk_cmd(OP_MATCH, FAM_V6, 64'hC0A8_0101_0000_0000, '0, 1'b0, '0, '0, '0));
      queue_cmd(mk_cmd(OP_MATCH, FAM_V4, 64'hC0A8_0101_FFFF_0000, rand64(), 1'b1, 8'd7,
                       rand64(), rand64()));
      queue_cmd(mk_cmd(OP_MATCH, FAM_V4, 64'hC0A8_0100_0000_0000, '0, 1'b0, '0, '0, '0));
      queue_cmd(mk_cmd(OP_ADD, FAM_V6, '1, '1, 1'b0, PREFIX_MAX_V6, '0, '0));
      queue_cmd(mk_cmd(OP_MATCH, FAM_V6, '1, '1, 1'b0, '0, '0, '0));
      queue_cmd(mk_cmd(OP_MATCH, FAM_V6, '1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, '0, '0, '0));
      queue_cmd(mk_cmd(OP_ADD, FAM_V6, 64'h2001_0DB8_0000_0001, rand64(), 1'b0, 8'd64,
                       '0, '0));
      queue_cmd(mk_cmd(OP_MATCH, FAM_V6, 64'h2001_0DB8_0000_0001, rand64(), 1'b0, '0,
                       '0, '0));
      queue_cmd(mk_cmd(OP_ADD, FAM_V6, 64'h2001_0DB8_0000_0002, 64'h8000_0000_0000_0000,
                       1'b0, 8'd65, '0, '0));
      queue_cmd(mk_cmd(OP_MATCH, FAM_V6, 64'h2001_0DB8_0000_0002, 64'h7FFF_FFFF_FFFF_FFFF,
                       1'b0, '0, '0, '0));
      queue_cmd(mk_cmd(OP_MATCH, FAM_V6, 64'h2001_0DB8_0000_0002, 64'hFFFF_FFFF_FFFF_FFFF,
                       1'b0, '0, '0, '0));
      queue_cmd(mk_cmd(OP_ADD, FAM_V6, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                       1'b1, 8'd255, 64'hF0F0_F0F0_F0F0_F0F0, 64'h0000_0000_0000_00FF));
      queue_cmd(mk_cmd(OP_MATCH, FAM_V6, 64'h0E2C_4A68_86A4_C2E0, 64'h0123_4567_89AB_CD10,
                       1'b0, '0, '0, '0));
      queue_cmd(mk_cmd(OP_ADD, FAM_V4, 64'h0A00_0001_FFFF_FFFF, '1, 1'b1, 8'd200, '1, '1));
      queue_cmd(mk_cmd(OP_MATCH, FAM_V4, 64'h0A00_0001_0000_0000, '0, 1'b0, '0, '0, '0));

      // Random traffic: sender idles often, very often, then never
      run_phase(38, PHASE_CMDS);
      run_phase(77, PHASE_CMDS);
      run_phase(0, PHASE_CMDS - 1);

      // Catch-all IPv4 subnet, fill the table, hit the full condition, then match
      if (planted_q.size() < TABLE_DEPTH)
         queue_cmd(mk_cmd(OP_ADD, FAM_V4, rand64(), rand64(), 1'b0, 8'd0, rand64(),
                          rand64()));
      while (planted_q.size() < TABLE_DEPTH)
         queue_cmd(mk_cmd(OP_ADD, FAM_V6, rand64(), rand64(), 1'b0, PREFIX_MAX_V6, '0, '0));
      queue_cmd(mk_cmd(OP_ADD, FAM_V4, rand64(), '0, 1'b0, 8'd255, '0, '0));
      queue_cmd(mk_cmd(OP_ADD, FAM_V6, rand64(), rand64(), 1'b1, 8'd255, '1, '1));
      queue_cmd(mk_cmd(OP_ADD, FAM_V4, rand64(), '0, 1'b0, 8'd24, '0, '0));
      repeat (24) queue_cmd(rand_match());
      while (cmd_q.size() != 0) @(posedge clock);

      // Drain: wait for every status, then watch for strays
      while (status_owed.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d adds and %0d matches against a table of up to %0d subnets",
               n_adds, n_matches, TABLE_DEPTH);
      $display("Statuses: %0d ok, %0d no match, %0d prefix range, %0d table full",
               status_seen[STATUS_OK], status_seen[STATUS_NOMATCH],
               status_seen[STATUS_RANGE], status_seen[STATUS_FULL]);
      if (fail_count == 0) begin
         $display("subnet_table_match_core: match");
      end else begin
         $display("subnet_table_match_core: mismatch");
      end
      $finish;
   end

endmodule
